>>> rtl/clas_pkg.sv
package clas_pkg;

  localparam int COUNT_BITS = 16;
  localparam int UNIT_BITS  = 16;
  localparam int ARG_BITS   = 16;
  localparam int RUN_BITS   = 16;

  localparam logic [UNIT_BITS-1:0] U_NUL    = 16'h0000;
  localparam logic [UNIT_BITS-1:0] U_TAB    = 16'h0009;
  localparam logic [UNIT_BITS-1:0] U_SPACE  = 16'h0020;
  localparam logic [UNIT_BITS-1:0] U_QUOTE  = 16'h0022;
  localparam logic [UNIT_BITS-1:0] U_BSLASH = 16'h005C;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [ARG_BITS-1:0]   ARG_MAX   = {ARG_BITS{1'b1}};
  localparam logic [RUN_BITS-1:0]   RUN_MAX   = {RUN_BITS{1'b1}};

  typedef enum logic [4:0] {
    MODE_START        = 5'b00001,
    MODE_FIRST_QUOTED = 5'b00010,
    MODE_FIRST_PLAIN  = 5'b00100,
    MODE_GAP          = 5'b01000,
    MODE_IN_ARG       = 5'b10000
  } mode_t;

  typedef struct packed {
    mode_t                  mode;
    logic                   quoting;
    logic                   quote_just_closed;
    logic [COUNT_BITS-1:0]  pending;
    logic [ARG_BITS-1:0]    current_arg;
  } state_t;

  typedef struct packed {
    logic [UNIT_BITS-1:0] char_out;
    logic                 char_valid;
    logic [RUN_BITS-1:0]  backslash_run;
    logic [ARG_BITS-1:0]  arg_index;
    logic                 arg_end;
    logic                 line_done;
  } result_t;

  localparam state_t STATE_RST = '{
    mode:              MODE_START,
    quoting:           1'b0,
    quote_just_closed: 1'b0,
    pending:           '0,
    current_arg:       '0
  };

  function automatic logic [RUN_BITS-1:0] sat_run(input logic [COUNT_BITS-1:0] n);
    logic [31:0] w;
    w = 32'(n);
    sat_run = (w > 32'(RUN_MAX)) ? RUN_MAX : w[RUN_BITS-1:0];
  endfunction

endpackage

>>> rtl/clas_channels.sv
interface clas_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;

  modport source (output valid, output code_unit, input ready);
  modport sink   (input valid, input code_unit, output ready);
endinterface

interface clas_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_out;
  logic        char_valid;
  logic [15:0] backslash_run;
  logic [15:0] arg_index;
  logic        arg_end;
  logic        line_done;

  modport source (output valid, output char_out, output char_valid, output backslash_run,
                  output arg_index, output arg_end, output line_done, input ready);
  modport sink   (input valid, input char_out, input char_valid, input backslash_run,
                  input arg_index, input arg_end, input line_done, output ready);
endinterface

>>> rtl/command_line_argument_splitter.sv
// Splits a UTF-16 command line into arguments by the usual Windows rules, one
// code unit per request, with code 0 ending the line. Each request gives zero
// or one result: a count of backslashes to append, then at most one code unit,
// plus the argument index and end-of-argument / end-of-line flags. A new
// request is taken every cycle; the only limit is the single result register,
// which still accepts a request in the cycle its result is taken. A result is
// valid in the cycle after its request. Parser state clears after each end of line.
module command_line_argument_splitter (
  input  logic        clk,
  input  logic        rst_n,
  clas_in_if.sink     in_ch,
  clas_out_if.source  out_ch
);
  import clas_pkg::*;

  state_t  state_r;
  state_t  state_nxt;
  result_t res_r;
  result_t res_nxt;
  logic    emit;
  logic    out_valid_r;
  logic    accept;

  clas_parse u_parse (
    .code_unit (in_ch.code_unit),
    .cur       (state_r),
    .nxt       (state_nxt),
    .emit      (emit),
    .res       (res_nxt)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RST;
      out_valid_r <= 1'b0;
    end else if (accept) begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.char_out      = res_r.char_out;
  assign out_ch.char_valid    = res_r.char_valid;
  assign out_ch.backslash_run = res_r.backslash_run;
  assign out_ch.arg_index     = res_r.arg_index;
  assign out_ch.arg_end       = res_r.arg_end;
  assign out_ch.line_done     = res_r.line_done;

`ifndef NO_ASSERTIONS
  a_line_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit && res_nxt.line_done) |=>
      (state_r.mode == MODE_START && state_r.current_arg == '0 && state_r.pending == '0))
    else $error("state not cleared after end of line");

  a_arg_end_to_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit && res_nxt.arg_end && !res_nxt.line_done) |=> (state_r.mode == MODE_GAP))
    else $error("argument ended without entering gap");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.char_valid || res_r.char_out == '0))
    else $error("char_out nonzero without char_valid");
`endif

endmodule

>>> rtl/clas_parse.sv
module clas_parse (
  input  logic [15:0]     code_unit,
  input  clas_pkg::state_t cur,
  output clas_pkg::state_t nxt,
  output logic            emit,
  output clas_pkg::result_t res
);
  import clas_pkg::*;

  logic                  go_arg;
  logic                  clr;
  logic                  handled;
  logic                  is_blank;
  logic [COUNT_BITS-1:0] n;
  state_t                st;
  result_t               r;

  assign is_blank = (code_unit == U_SPACE) || (code_unit == U_TAB);

  always_comb begin
    st      = cur;
    r       = '0;
    emit    = 1'b0;
    go_arg  = 1'b0;
    clr     = 1'b0;
    handled = 1'b0;
    n       = cur.pending;
    case (cur.mode)
      MODE_START: begin
        if (code_unit == U_NUL) begin
          emit = 1'b1; r.arg_end = 1'b1; r.line_done = 1'b1; clr = 1'b1;
        end else if (code_unit == U_QUOTE) begin
          st.mode = MODE_FIRST_QUOTED;
        end else if (code_unit > U_SPACE) begin
          st.mode = MODE_FIRST_PLAIN;
          emit = 1'b1; r.char_valid = 1'b1; r.char_out = code_unit;
        end else begin
          st.mode = MODE_GAP;
          emit = 1'b1; r.arg_end = 1'b1;
        end
      end
      MODE_FIRST_QUOTED: begin
        if (code_unit == U_NUL) begin
          emit = 1'b1; r.arg_end = 1'b1; r.line_done = 1'b1; clr = 1'b1;
        end else if (code_unit == U_QUOTE) begin
          st.mode = MODE_GAP;
          emit = 1'b1; r.arg_end = 1'b1;
        end else begin
          emit = 1'b1; r.char_valid = 1'b1; r.char_out = code_unit;
        end
      end
      MODE_FIRST_PLAIN: begin
        if (code_unit == U_NUL) begin
          emit = 1'b1; r.arg_end = 1'b1; r.line_done = 1'b1; clr = 1'b1;
        end else if (code_unit > U_SPACE) begin
          emit = 1'b1; r.char_valid = 1'b1; r.char_out = code_unit;
        end else begin
          st.mode = MODE_GAP;
          emit = 1'b1; r.arg_end = 1'b1;
        end
      end
      MODE_GAP: begin
        if (is_blank) begin
          st = cur;
        end else if (code_unit == U_NUL) begin
          emit = 1'b1; r.line_done = 1'b1; clr = 1'b1;
        end else begin
          if (cur.current_arg != ARG_MAX) st.current_arg = cur.current_arg + 1'b1;
          st.mode              = MODE_IN_ARG;
          st.quoting           = 1'b0;
          st.quote_just_closed = 1'b0;
          st.pending           = '0;
          go_arg               = 1'b1;
        end
      end
      MODE_IN_ARG: begin
        go_arg = 1'b1;
      end
      default: begin
        clr = 1'b1;
      end
    endcase

    if (go_arg) begin
      n = st.pending;
      if (st.quote_just_closed) begin
        st.quote_just_closed = 1'b0;
        if (code_unit == U_QUOTE) begin
          emit = 1'b1; r.char_valid = 1'b1; r.char_out = U_QUOTE;
          handled = 1'b1;
        end
      end
      if (!handled) begin
        if (code_unit == U_BSLASH) begin
          if (st.pending != COUNT_MAX) st.pending = st.pending + 1'b1;
        end else begin
          st.pending = '0;
          if (code_unit == U_QUOTE) begin
            r.backslash_run = sat_run(n >> 1);
            if (!n[0]) begin
              if (st.quoting) begin
                st.quoting           = 1'b0;
                st.quote_just_closed = 1'b1;
              end else begin
                st.quoting = 1'b1;
              end
              emit = ((n >> 1) != '0);
            end else begin
              emit = 1'b1; r.char_valid = 1'b1; r.char_out = U_QUOTE;
            end
          end else if (code_unit == U_NUL) begin
            emit = 1'b1; r.backslash_run = sat_run(n);
            r.arg_end = 1'b1; r.line_done = 1'b1; clr = 1'b1;
          end else if (!st.quoting && is_blank) begin
            st.mode = MODE_GAP;
            emit = 1'b1; r.backslash_run = sat_run(n); r.arg_end = 1'b1;
          end else begin
            emit = 1'b1; r.backslash_run = sat_run(n);
            r.char_valid = 1'b1; r.char_out = code_unit;
          end
        end
      end
    end

    r.arg_index = st.current_arg;
    if (clr) st = STATE_RST;
  end

  assign nxt = st;
  assign res = r;

endmodule
